@@ src/frequency_mult_shift_calc_assert.svh @@
// Assertion macros for the clock factor calculator.
`ifndef FREQUENCY_MULT_SHIFT_CALC_ASSERT_SVH
`define FREQUENCY_MULT_SHIFT_CALC_ASSERT_SVH

`ifndef SYNTH
`define FMSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define FMSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FMSC_ASSERT_IMP(lbl, ante, cons, msg)
`define FMSC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/fmsc_pkg.sv @@
package fmsc_pkg;

  localparam int unsigned FreqW  = 64;
  localparam int unsigned ShiftW = 7;
  localparam int unsigned LzW    = 6;
  localparam int unsigned IterW  = 8;

  localparam logic [IterW-1:0] DivIters  = 8'd128;
  localparam logic [IterW-1:0] IterBias  = 8'd64;

  typedef struct packed {
    logic load;
    logic step;
  } unit_ctl_t;

  typedef struct packed {
    logic             done;
    logic [IterW-1:0] iter;
  } div_stat_t;

endpackage

@@ src/fmsc_if.sv @@
interface fmsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [fmsc_pkg::FreqW-1:0]   source_freq;
  logic [fmsc_pkg::FreqW-1:0]   dest_freq;

  modport source (output valid, source_freq, dest_freq, input ready);
  modport sink   (input valid, source_freq, dest_freq, output ready);
endinterface

interface fmsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [fmsc_pkg::FreqW-1:0]   multiplier;
  logic [fmsc_pkg::ShiftW-1:0]  shift;
  logic                         error;

  modport source (output valid, multiplier, shift, error, input ready);
  modport sink   (input valid, multiplier, shift, error, output ready);
endinterface

@@ src/fmsc_norm.sv @@
module fmsc_norm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fmsc_pkg::unit_ctl_t         ctl_i,
  input  logic [fmsc_pkg::FreqW-1:0]  value_i,
  output logic [fmsc_pkg::FreqW-1:0]  value_o,
  output logic [fmsc_pkg::LzW-1:0]    count_o,
  output logic                        done_o
);

  logic [fmsc_pkg::FreqW-1:0] val_q, val_d;
  logic [fmsc_pkg::LzW-1:0]   cnt_q, cnt_d;

  always_comb begin
    val_d = val_q;
    cnt_d = cnt_q;
    if (ctl_i.load) begin
      val_d = value_i;
      cnt_d = '0;
    end else if (ctl_i.step) begin
      val_d = {val_q[fmsc_pkg::FreqW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign value_o = val_q;
  assign count_o = cnt_q;
  assign done_o  = val_q[fmsc_pkg::FreqW-1];

endmodule

@@ src/fmsc_div.sv @@
module fmsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fmsc_pkg::unit_ctl_t         ctl_i,
  input  logic [fmsc_pkg::FreqW-1:0]  dividend_i,
  input  logic [fmsc_pkg::FreqW-1:0]  divisor_i,
  output logic [fmsc_pkg::FreqW-1:0]  quotient_o,
  output fmsc_pkg::div_stat_t         stat_o
);

  localparam int unsigned W = fmsc_pkg::FreqW;

  logic [W-1:0]                 num_q, num_d;
  logic [W-1:0]                 rem_q, rem_d;
  logic [W-1:0]                 quo_q, quo_d;
  logic [W-1:0]                 dvs_q, dvs_d;
  logic [fmsc_pkg::IterW-1:0]   iter_q, iter_d;
  logic [W:0]                   part;
  logic [W:0]                   diff;
  logic                         take;

  // upper half of the dividend is the normalized value, lower half zeros
  assign part = {rem_q, num_q[W-1]};
  assign diff = part - {1'b0, dvs_q};
  assign take = (part >= {1'b0, dvs_q});

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    iter_d = iter_q;
    if (ctl_i.load) begin
      num_d  = dividend_i;
      rem_d  = '0;
      quo_d  = '0;
      dvs_d  = divisor_i;
      iter_d = '0;
    end else if (ctl_i.step) begin
      num_d  = {num_q[W-2:0], 1'b0};
      rem_d  = take ? diff[W-1:0] : part[W-1:0];
      quo_d  = {quo_q[W-2:0], take};
      iter_d = iter_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else begin
      iter_q <= iter_d;
    end
  end

  // stop once the quotient holds 64 bits from its leading one down, or after DivIters steps
  assign quotient_o  = quo_q;
  assign stat_o.done = quo_q[W-1] || (iter_q == fmsc_pkg::DivIters);
  assign stat_o.iter = iter_q;

endmodule

@@ src/frequency_mult_shift_calc.sv @@
// Flow: a zero frequency goes from accept straight to the finish state; otherwise
//   dest_freq is shifted left until its top bit is set, then divided by source_freq
//   in the one-bit-per-cycle restoring divider before the finish state.
// Throughput: one word at a time; a new word is taken the cycle after the
//   previous result enters the output register; the finish state waits for it to be free.
// Reset: asynchronous, active low; clears the sequencer and output valid.
`include "frequency_mult_shift_calc_assert.svh"

module frequency_mult_shift_calc (
  input  logic              clk_i,
  input  logic              rst_ni,
  fmsc_in_if.sink           in_i,
  fmsc_out_if.source        out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NORM = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                         state_q, state_d;
  logic                               err_q, err_d;
  logic [fmsc_pkg::FreqW-1:0]         src_q, src_d;
  logic                               out_valid_q, out_valid_d;
  logic [fmsc_pkg::FreqW-1:0]         out_mult_q, out_mult_d;
  logic [fmsc_pkg::ShiftW-1:0]        out_shift_q, out_shift_d;
  logic                               out_err_q, out_err_d;

  fmsc_pkg::unit_ctl_t                norm_ctl, div_ctl;
  fmsc_pkg::div_stat_t                div_stat;
  logic [fmsc_pkg::FreqW-1:0]         norm_val;
  logic [fmsc_pkg::LzW-1:0]           norm_cnt;
  logic                               norm_done;
  logic [fmsc_pkg::FreqW-1:0]         quot;
  logic [fmsc_pkg::IterW-1:0]         shift_sum;
  logic                               in_acc, out_free;

  fmsc_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (norm_ctl),
    .value_i (in_i.dest_freq),
    .value_o (norm_val),
    .count_o (norm_cnt),
    .done_o  (norm_done)
  );

  fmsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (norm_val),
    .divisor_i  (src_q),
    .quotient_o (quot),
    .stat_o     (div_stat)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign shift_sum  = {{(fmsc_pkg::IterW-fmsc_pkg::LzW){1'b0}}, norm_cnt}
                      + div_stat.iter - fmsc_pkg::IterBias;

  always_comb begin
    state_d      = state_q;
    err_d        = err_q;
    src_d        = src_q;
    norm_ctl     = '0;
    div_ctl      = '0;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_mult_d   = out_mult_q;
    out_shift_d  = out_shift_q;
    out_err_d    = out_err_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          src_d         = in_i.source_freq;
          norm_ctl.load = 1'b1;
          if ((in_i.source_freq == '0) || (in_i.dest_freq == '0)) begin
            err_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            err_d   = 1'b0;
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          div_ctl.load = 1'b1;
          state_d      = ST_DIV;
        end else begin
          norm_ctl.step = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_FIN;
        end else begin
          div_ctl.step = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_err_d   = err_q;
          out_mult_d  = err_q ? '0 : quot;
          out_shift_d = err_q ? '0 : shift_sum[fmsc_pkg::ShiftW-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    out_mult_q  <= out_mult_d;
    out_shift_q <= out_shift_d;
    out_err_q   <= out_err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.multiplier = out_mult_q;
  assign out_o.shift      = out_shift_q;
  assign out_o.error      = out_err_q;

  `FMSC_ASSERT_IMP(a_err_zero, out_valid_q && out_err_q, (out_mult_q == '0) && (out_shift_q == '0), "error word carries nonzero fields")
  `FMSC_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, (src_q != '0) && norm_val[fmsc_pkg::FreqW-1], "divide with zero divisor or unnormalized dividend")
  `FMSC_ASSERT_IMP(a_iter_bound, state_q == ST_DIV, div_stat.iter <= fmsc_pkg::DivIters, "divider ran past its step count")
  `FMSC_ASSERT_NXT(a_fin_out, (state_q == ST_FIN) && out_free, out_valid_q && (state_q == ST_IDLE), "finished word not handed to output")

endmodule
